FILE: hw/rtl/lqe_pkg.sv
`default_nettype none
package lqe_pkg;

  typedef enum logic [2:0] {
    MODE_TX    = 3'd0,
    MODE_RX    = 3'd1,
    MODE_AGE   = 3'd2,
    MODE_CLEAR = 3'd3,
    MODE_QUERY = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    TX_ACKED = 2'd0,
    TX_NOACK = 2'd1,
    TX_QFULL = 2'd2,
    TX_ERROR = 2'd3
  } tx_status_t;

  typedef enum logic [1:0] {
    CFG_ETX_FROM_COUNT = 2'd0,
    CFG_INIT_ETX_RSSI  = 2'd1,
    CFG_FRESH_EXPIRY   = 2'd2,
    CFG_NOACK_PENALTY  = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DIV,
    ST_WRITE,
    ST_AGE,
    ST_RESULT
  } state_t;

  localparam int unsigned FRESH_MAX    = 16;
  localparam int unsigned FRESH_TARGET = 4;
  localparam int unsigned COUNT_LIMIT  = 32;
  localparam int unsigned SCALE        = 100;
  localparam int unsigned ALPHA_SLOW   = 10;
  localparam int unsigned ALPHA_FAST   = 25;
  localparam int unsigned DEFAULT_ETX  = 2;
  localparam int          RSSI_HI      = -50;
  localparam int          RSSI_LO      = -75;
  localparam int unsigned INIT_ETX_CAP = 3;
  localparam int unsigned DIV_BITS     = 24;

  // Division by SCALE as a multiply and shift. The short form is exact for
  // magnitudes up to 12800, the long form for values below 2^23.
  localparam int unsigned DIV100_SHORT_MUL   = 5243;
  localparam int unsigned DIV100_SHORT_SHIFT = 19;
  localparam int unsigned DIV100_LONG_MUL    = 10737419;
  localparam int unsigned DIV100_LONG_SHIFT  = 30;

  // Commands from the controller into the datapath.
  typedef struct packed {
    logic load;
    logic calc;
    logic div_start;
    logic write;
    logic age_step;
    logic age_first;
    logic clear;
  } cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic age_last;
  } stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lqe_if.sv
`default_nettype none
interface lqe_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [3:0]  slot;
  logic [1:0]  tx_status;
  logic [4:0]  tx_attempts;
  logic signed [7:0] rssi;
  logic [31:0] now;
  modport source (output valid, mode, slot, tx_status, tx_attempts, rssi, now, input ready);
  modport sink (input valid, mode, slot, tx_status, tx_attempts, rssi, now, output ready);
endinterface

interface lqe_out_if;
  logic        valid;
  logic        ready;
  logic        entry_valid;
  logic [15:0] etx_out;
  logic signed [7:0] rssi_out;
  logic        rssi_known;
  logic [4:0]  freshness_out;
  logic        is_fresh;
  modport source (output valid, entry_valid, etx_out, rssi_out, rssi_known, freshness_out,
                  is_fresh, input ready);
  modport sink (input valid, entry_valid, etx_out, rssi_out, rssi_known, freshness_out,
                is_fresh, output ready);
endinterface

interface lqe_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/lqe_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module lqe_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [lqe_pkg::DIV_BITS-1:0] dividend,
  input  wire logic [lqe_pkg::DIV_BITS-1:0] divisor,
  output logic             busy,
  output logic [lqe_pkg::DIV_BITS-1:0] quotient
);
  localparam int unsigned W = lqe_pkg::DIV_BITS;
  logic [W-1:0] rem, dvs, quo;
  logic [$clog2(W+1)-1:0] cnt;
  logic [W:0] trial;

  assign trial = {rem[W-2:0], quo[W-1]} - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= ($clog2(W+1))'(W);
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      if (!trial[W] || rem[W-1]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == 1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/lqe_datapath.sv
`default_nettype none
module lqe_datapath #(
  parameter int unsigned NEIGHBORS = 16,
  parameter int unsigned ETX_UNIT  = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire lqe_pkg::cmd_t cmd,
  output lqe_pkg::stat_t   stat,
  input  wire logic [2:0]  mode,
  input  wire logic [3:0]  slot,
  input  wire logic [1:0]  tx_status,
  input  wire logic [4:0]  tx_attempts,
  input  wire logic signed [7:0] rssi,
  input  wire logic [31:0] now,
  input  wire logic        etx_from_count,
  input  wire logic        init_etx_from_rssi,
  input  wire logic [31:0] fresh_expiry_ticks,
  input  wire logic [4:0]  noack_penalty,
  output logic             entry_valid,
  output logic [15:0]      etx_out,
  output logic signed [7:0] rssi_out,
  output logic             rssi_known,
  output logic [4:0]       freshness_out,
  output logic             is_fresh
);
  localparam int unsigned AW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam int unsigned DW = lqe_pkg::DIV_BITS;

  logic [NEIGHBORS-1:0] used;
  logic [15:0] etx_m   [NEIGHBORS];
  logic [7:0]  rssi_m  [NEIGHBORS];
  logic [NEIGHBORS-1:0] seen;
  logic [4:0]  fr_m    [NEIGHBORS];
  logic [31:0] ts_m    [NEIGHBORS];
  logic [7:0]  sc_m    [NEIGHBORS];
  logic [7:0]  ac_m    [NEIGHBORS];

  // Working copy of the addressed entry.
  logic        ok;
  logic [AW-1:0] idx;
  logic        w_used, w_seen;
  logic [15:0] w_etx;
  logic signed [7:0] w_rssi;
  logic [4:0]  w_fr;
  logic [31:0] w_ts;
  logic [7:0]  w_sc, w_ac;
  logic        need_div;
  logic        use_recip;
  logic [DW-1:0] div_num, div_den;
  logic        div_busy;
  logic [DW-1:0] div_q;
  logic [AW-1:0] age_idx;

  assign ok  = ({{(32-4){1'b0}}, slot} < 32'(NEIGHBORS));
  assign idx = AW'(slot);

  function automatic logic [15:0] sat16(input logic [31:0] v);
    return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  // Combinational update of the working copy.
  logic        c_used, c_seen, c_fresh, c_nodiv, c_recip;
  logic [15:0] c_etx;
  logic signed [7:0] c_rssi;
  logic [4:0]  c_fr;
  logic [31:0] c_ts;
  logic [7:0]  c_sc, c_ac;
  logic [DW-1:0] c_num, c_den;
  logic [5:0]  n;
  logic [5:0]  fsum;
  logic [8:0]  scn;
  logic [7:0]  sch, ach;
  logic [31:0] etxw;
  logic signed [15:0] rv;
  logic [15:0] rmag;
  logic [31:0] rprod;
  logic [7:0]  rq;
  logic signed [7:0] rb;

  always_comb begin
    c_used = w_used; c_seen = w_seen; c_etx = w_etx; c_rssi = w_rssi; c_fr = w_fr;
    c_ts = w_ts; c_sc = w_sc; c_ac = w_ac; c_nodiv = 1'b1; c_recip = 1'b0;
    c_num = '0; c_den = 24'd1;
    n = {1'b0, tx_attempts} + ((tx_status == lqe_pkg::TX_NOACK) ? {1'b0, noack_penalty} : 6'd0);
    fsum = '0;
    scn = '0; sch = w_sc; ach = w_ac; etxw = '0; rv = '0; rb = '0;
    rmag = '0; rprod = '0; rq = '0;
    c_fresh = 1'b0;
    if (ok && mode == lqe_pkg::MODE_TX && tx_status != lqe_pkg::TX_ERROR
        && (w_used || tx_status == lqe_pkg::TX_ACKED)) begin
      if (!w_used) begin
        c_used = 1'b1; c_seen = 1'b0; c_etx = '0; c_rssi = '0; c_fr = '0;
        c_ts = '0; c_sc = '0; c_ac = '0; c_fresh = 1'b0;
      end
      if (tx_status != lqe_pkg::TX_QFULL) begin
        c_ts = now;
        fsum = {1'b0, c_fr} + {1'b0, tx_attempts};
        c_fr = (fsum > 6'(lqe_pkg::FRESH_MAX)) ? 5'(lqe_pkg::FRESH_MAX) : fsum[4:0];
        // The send time was just set to now, so only the expiry and the new
        // freshness decide.
        c_fresh = (fresh_expiry_ticks != 32'd0) && (c_fr >= 5'(lqe_pkg::FRESH_TARGET));
        if (etx_from_count) begin
          sch = c_sc; ach = c_ac;
          if ({1'b0, c_sc} + {3'b0, n} > 9'(lqe_pkg::COUNT_LIMIT)) begin
            sch = {1'b0, c_sc[7:1]}; ach = {1'b0, c_ac[7:1]};
          end
          scn = {1'b0, sch} + {3'b0, n};
          c_sc = scn[8] ? 8'hFF : scn[7:0];
          c_ac = (tx_status == lqe_pkg::TX_ACKED && ach != 8'hFF) ? ach + 1'b1 : ach;
          if (c_ac != 0) begin
            c_nodiv = 1'b0;
            c_num = DW'({24'd0, c_sc} * 32'(ETX_UNIT));
            c_den = DW'(c_ac);
          end else begin
            c_etx = sat16(((c_sc > {3'b0, noack_penalty}) ? 32'(c_sc) : 32'(noack_penalty))
                          * 32'(ETX_UNIT));
          end
        end else if (c_etx == 0) begin
          c_etx = sat16(32'(n) * 32'(ETX_UNIT));
        end else begin
          c_recip = 1'b1;
          etxw = 32'(c_etx) * (c_fresh ? 32'(lqe_pkg::SCALE - lqe_pkg::ALPHA_SLOW)
                                       : 32'(lqe_pkg::SCALE - lqe_pkg::ALPHA_FAST))
               + 32'(n) * 32'(ETX_UNIT) * (c_fresh ? 32'(lqe_pkg::ALPHA_SLOW)
                                                   : 32'(lqe_pkg::ALPHA_FAST));
          c_num = etxw[DW-1:0];
        end
      end
    end else if (ok && mode == lqe_pkg::MODE_RX) begin
      if (!w_used) begin
        c_used = 1'b1; c_seen = 1'b0; c_etx = '0; c_rssi = '0; c_fr = '0;
        c_ts = '0; c_sc = '0; c_ac = '0;
      end
      if (!c_seen) begin
        c_rssi = rssi;
      end else begin
        // Divide the magnitude so the quotient truncates toward zero.
        rv = 16'(c_rssi) * 16'(lqe_pkg::SCALE - lqe_pkg::ALPHA_SLOW)
           + 16'(rssi) * 16'(lqe_pkg::ALPHA_SLOW);
        rmag = rv[15] ? 16'(-rv) : 16'(rv);
        rprod = 32'(rmag) * 32'(lqe_pkg::DIV100_SHORT_MUL);
        rq = 8'(rprod >> lqe_pkg::DIV100_SHORT_SHIFT);
        c_rssi = rv[15] ? 8'(-rq) : rq;
      end
      c_seen = 1'b1;
      if (c_etx == 0) begin
        if (init_etx_from_rssi) begin
          rb = c_rssi;
          if (rb > 8'(lqe_pkg::RSSI_HI)) rb = 8'(lqe_pkg::RSSI_HI);
          if (rb < 8'(lqe_pkg::RSSI_LO + 1)) rb = 8'(lqe_pkg::RSSI_LO + 1);
          c_nodiv = 1'b0;
          c_num = DW'((lqe_pkg::RSSI_HI - lqe_pkg::RSSI_LO) * ETX_UNIT);
          c_den = DW'(8'(rb - 8'(lqe_pkg::RSSI_LO)));
        end else begin
          c_etx = sat16(32'(lqe_pkg::DEFAULT_ETX) * 32'(ETX_UNIT));
        end
      end
    end
  end

  lqe_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_num),
    .divisor(div_den), .busy(div_busy), .quotient(div_q)
  );

  logic [2*DW-1:0] recip_prod;
  logic [DW-1:0] q_val;
  assign recip_prod = (2*DW)'(div_num) * (2*DW)'(lqe_pkg::DIV100_LONG_MUL);
  assign q_val = use_recip ? DW'(recip_prod >> lqe_pkg::DIV100_LONG_SHIFT) : div_q;

  logic div_rssi;
  logic [31:0] etx_cap;
  assign etx_cap = (div_rssi && 32'(q_val) > 32'(lqe_pkg::INIT_ETX_CAP * ETX_UNIT))
                 ? 32'(lqe_pkg::INIT_ETX_CAP * ETX_UNIT) : 32'(q_val);

  assign stat.need_div = need_div;
  assign stat.div_busy = div_busy;
  assign stat.age_last = (32'(age_idx) == 32'(NEIGHBORS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.clear) begin
      used <= '0;
    end else if (cmd.write && ok) begin
      used[idx] <= w_used;
    end
    if (cmd.load) begin
      w_used <= ok && used[idx];
      w_seen <= seen[idx];
      w_etx  <= etx_m[idx];
      w_rssi <= rssi_m[idx];
      w_fr   <= fr_m[idx];
      w_ts   <= ts_m[idx];
      w_sc   <= sc_m[idx];
      w_ac   <= ac_m[idx];
    end
    if (cmd.calc) begin
      w_used <= c_used; w_seen <= c_seen; w_etx <= c_etx; w_rssi <= c_rssi;
      w_fr <= c_fr; w_ts <= c_ts; w_sc <= c_sc; w_ac <= c_ac;
      need_div <= !c_nodiv;
      use_recip <= c_recip;
      div_num <= c_num; div_den <= c_den;
      div_rssi <= (mode == lqe_pkg::MODE_RX);
    end
    if ((need_div || use_recip) && !div_busy && !cmd.div_start && cmd.write) begin
      w_etx <= sat16(etx_cap);
    end
    if (cmd.write && ok) begin
      seen[idx] <= w_seen;
      etx_m[idx] <= (need_div || use_recip) ? sat16(etx_cap) : w_etx;
      rssi_m[idx] <= w_rssi;
      fr_m[idx] <= w_fr;
      ts_m[idx] <= w_ts;
      sc_m[idx] <= w_sc;
      ac_m[idx] <= w_ac;
    end
    if (cmd.age_first) age_idx <= '0;
    else if (cmd.age_step) begin
      if (used[age_idx]) fr_m[age_idx] <= {1'b0, fr_m[age_idx][4:1]};
      age_idx <= age_idx + 1'b1;
    end
  end

  // Result view of the addressed entry, read after all updates.
  logic [31:0] rage;
  assign rage = now - ts_m[idx];
  assign entry_valid   = ok && used[idx];
  assign etx_out       = entry_valid ? etx_m[idx] : '0;
  assign rssi_known    = entry_valid && seen[idx];
  assign rssi_out      = rssi_known ? rssi_m[idx] : '0;
  assign freshness_out = entry_valid ? fr_m[idx] : '0;
  assign is_fresh      = entry_valid && (rage < fresh_expiry_ticks)
                         && (fr_m[idx] >= 5'(lqe_pkg::FRESH_TARGET));
endmodule
`default_nettype wire

FILE: hw/rtl/lqe_ctrl.sv
`default_nettype none
module lqe_ctrl (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic [2:0] mode,
  output logic           res_load,
  input  wire logic      res_busy,
  output lqe_pkg::cmd_t  cmd,
  input  wire lqe_pkg::stat_t stat
);
  lqe_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= lqe_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    res_load = 1'b0;
    unique case (state)
      lqe_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (mode == lqe_pkg::MODE_AGE) begin
            cmd.age_first = 1'b1;
            state_next = lqe_pkg::ST_AGE;
          end else if (mode == lqe_pkg::MODE_CLEAR) begin
            cmd.clear = 1'b1;
            state_next = lqe_pkg::ST_RESULT;
          end else begin
            state_next = lqe_pkg::ST_READ;
          end
        end
      end
      lqe_pkg::ST_READ: begin
        cmd.calc = 1'b1;
        state_next = lqe_pkg::ST_CALC;
      end
      lqe_pkg::ST_CALC: begin
        if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_next = lqe_pkg::ST_DIV;
        end else begin
          state_next = lqe_pkg::ST_WRITE;
        end
      end
      lqe_pkg::ST_DIV: begin
        if (!stat.div_busy) state_next = lqe_pkg::ST_WRITE;
      end
      lqe_pkg::ST_WRITE: begin
        cmd.write = 1'b1;
        state_next = lqe_pkg::ST_RESULT;
      end
      lqe_pkg::ST_AGE: begin
        cmd.age_step = 1'b1;
        if (stat.age_last) state_next = lqe_pkg::ST_RESULT;
      end
      lqe_pkg::ST_RESULT: begin
        if (!res_busy) begin
          res_load = 1'b1;
          state_next = lqe_pkg::ST_IDLE;
        end
      end
      default: state_next = lqe_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: hw/rtl/link_quality_estimator.sv
`default_nettype none
// Channel   Role    Payload
// in_ch     sink    mode, slot, tx_status, tx_attempts, rssi, now
// out_ch    source  entry_valid, etx_out, rssi_out, rssi_known, freshness_out, is_fresh
// cfg_ch    sink    index, data
// A request passes the read, calc, write and result states before the result register
// loads, a clear goes straight to result, and count ETX or ETX from RSSI adds the div
// state of the 24-step shift-subtract divider; aging walks the table one entry a cycle.
// Reset empties the table at once; stores of unused entries are not cleared.
// The result sits in an output register, so a stalled output holds only the
// final handoff of the next request.
module link_quality_estimator #(
  parameter int unsigned NEIGHBORS = 16,
  parameter int unsigned ETX_UNIT  = 128
) (
  input wire logic clk,
  input wire logic rst,
  lqe_in_if.sink   in_ch,
  lqe_out_if.source out_ch,
  lqe_cfg_if.sink  cfg_ch
);
  logic        etx_from_count, init_etx_from_rssi;
  logic [31:0] fresh_expiry_ticks;
  logic [4:0]  noack_penalty;
  lqe_pkg::cmd_t  cmd;
  lqe_pkg::stat_t stat;
  logic res_load;
  logic [2:0]  mode;
  logic [3:0]  slot;
  logic [1:0]  tx_status;
  logic [4:0]  tx_attempts;
  logic signed [7:0] rssi;
  logic [31:0] now;
  logic        r_ev, r_rk, r_if;
  logic [15:0] r_etx;
  logic signed [7:0] r_rssi;
  logic [4:0]  r_fr;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      etx_from_count <= 1'b0;
      init_etx_from_rssi <= 1'b0;
      fresh_expiry_ticks <= 32'd76800;
      noack_penalty <= 5'd12;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        lqe_pkg::CFG_ETX_FROM_COUNT: etx_from_count <= cfg_ch.data[0];
        lqe_pkg::CFG_INIT_ETX_RSSI:  init_etx_from_rssi <= cfg_ch.data[0];
        lqe_pkg::CFG_FRESH_EXPIRY:   fresh_expiry_ticks <= cfg_ch.data;
        lqe_pkg::CFG_NOACK_PENALTY:  noack_penalty <= cfg_ch.data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mode <= in_ch.mode; slot <= in_ch.slot; tx_status <= in_ch.tx_status;
      tx_attempts <= in_ch.tx_attempts; rssi <= in_ch.rssi; now <= in_ch.now;
    end
  end

  // Load occurs in the idle accept cycle, before the fields are latched, so present
  // inputs to the memory read directly at accept.
  lqe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .mode(in_ch.mode), .res_load(res_load), .res_busy(out_ch.valid && !out_ch.ready),
    .cmd(cmd), .stat(stat)
  );

  logic [3:0] dp_slot;
  assign dp_slot = cmd.load ? in_ch.slot : slot;

  logic d_ev, d_rk, d_if;
  logic [15:0] d_etx;
  logic signed [7:0] d_rssi;
  logic [4:0] d_fr;

  lqe_datapath #(.NEIGHBORS(NEIGHBORS), .ETX_UNIT(ETX_UNIT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .mode(mode), .slot(dp_slot), .tx_status(tx_status), .tx_attempts(tx_attempts),
    .rssi(rssi), .now(now), .etx_from_count(etx_from_count),
    .init_etx_from_rssi(init_etx_from_rssi), .fresh_expiry_ticks(fresh_expiry_ticks),
    .noack_penalty(noack_penalty), .entry_valid(d_ev), .etx_out(d_etx),
    .rssi_out(d_rssi), .rssi_known(d_rk), .freshness_out(d_fr), .is_fresh(d_if)
  );

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (res_load) out_ch.valid <= 1'b1;
    else if (out_ch.ready) out_ch.valid <= 1'b0;
    if (res_load) begin
      r_ev <= d_ev; r_etx <= d_etx; r_rssi <= d_rssi; r_rk <= d_rk;
      r_fr <= d_fr; r_if <= d_if;
    end
  end
  assign out_ch.entry_valid = r_ev;
  assign out_ch.etx_out = r_etx;
  assign out_ch.rssi_out = r_rssi;
  assign out_ch.rssi_known = r_rk;
  assign out_ch.freshness_out = r_fr;
  assign out_ch.is_fresh = r_if;

  a_fresh_valid: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (!out_ch.is_fresh || out_ch.entry_valid)) else $error("fresh w/o entry");
  a_known_valid: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (!out_ch.rssi_known || out_ch.entry_valid)) else $error("rssi w/o entry");
  a_fr_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.freshness_out <= 5'd16)) else $error("freshness range");
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    res_load |=> out_ch.valid) else $error("result lost");
endmodule
`default_nettype wire

FILE: dv/tb_link_quality_estimator.sv
`timescale 1ns / 1ps
module tb_link_quality_estimator;

  typedef struct packed {
    logic        entry_valid;
    logic [15:0] etx;
    logic [7:0]  rssi;
    logic        rssi_known;
    logic [4:0]  freshness;
    logic        fresh;
  } report_t;

  typedef struct {
    lqe_pkg::mode_t      mode;
    logic [3:0]          slot;
    lqe_pkg::tx_status_t status;
    logic [4:0]          attempts;
    logic [7:0]          rssi;
    logic [31:0]         now;
    logic                typed;
    report_t             want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  lqe_in_if  in_ch ();
  lqe_out_if out_ch ();
  lqe_cfg_if cfg_ch ();

  link_quality_estimator dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
                              .cfg_ch(cfg_ch));

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  // Link table shadow and register copy.
  logic        count_mode;
  logic        rssi_init;
  logic [31:0] expiry;
  logic [4:0]  penalty;
  logic        used [16];
  logic [15:0] etx_tab [16];
  logic signed [7:0] rssi_tab [16];
  logic        seen [16];
  logic [4:0]  fresh_tab [16];
  logic [31:0] sent_at [16];
  logic [7:0]  sends [16];
  logic [7:0]  acks [16];

  report_t pending_reports [$];
  int errors = 0;
  logic hold_sink = 0;
  logic [31:0] tick = 0;

  function automatic logic [15:0] clip16(longint unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic fresh_at(int s, logic [31:0] t);
    logic [31:0] age;
    age = t - sent_at[s];
    return used[s] && (age < expiry) && (fresh_tab[s] >= lqe_pkg::FRESH_TARGET);
  endfunction

  function automatic void open_entry(int s);
    used[s] = 1; etx_tab[s] = 0; rssi_tab[s] = 0; seen[s] = 0;
    fresh_tab[s] = 0; sent_at[s] = 0; sends[s] = 0; acks[s] = 0;
  endfunction

  function automatic logic [15:0] etx_from_rssi(int r);
    int b;
    longint unsigned e;
    b = r;
    if (b > lqe_pkg::RSSI_HI) b = lqe_pkg::RSSI_HI;
    if (b < lqe_pkg::RSSI_LO + 1) b = lqe_pkg::RSSI_LO + 1;
    e = ((lqe_pkg::RSSI_HI - lqe_pkg::RSSI_LO) * 128) / (b - lqe_pkg::RSSI_LO);
    if (e > lqe_pkg::INIT_ETX_CAP * 128) e = lqe_pkg::INIT_ETX_CAP * 128;
    return clip16(e);
  endfunction

  function automatic void apply_tx(int s, lqe_pkg::tx_status_t st, int att, logic [31:0] t);
    int unsigned n, f, sc, ac, a;
    longint unsigned sample;
    if (st == lqe_pkg::TX_ERROR) return;
    if (!used[s]) begin
      if (st != lqe_pkg::TX_ACKED) return;
      open_entry(s);
    end
    if (st == lqe_pkg::TX_QFULL) return;
    sent_at[s] = t;
    f = fresh_tab[s] + att;
    fresh_tab[s] = 5'((f > lqe_pkg::FRESH_MAX) ? lqe_pkg::FRESH_MAX : f);
    n = att;
    if (st == lqe_pkg::TX_NOACK) n += penalty;
    if (count_mode) begin
      sc = sends[s]; ac = acks[s];
      if (sc + n > lqe_pkg::COUNT_LIMIT) begin
        sc /= 2; ac /= 2;
      end
      sc += n;
      if (sc > 255) sc = 255;
      if (st == lqe_pkg::TX_ACKED && ac < 255) ac++;
      sends[s] = 8'(sc); acks[s] = 8'(ac);
      if (ac > 0) etx_tab[s] = clip16((sc * 128) / ac);
      else etx_tab[s] = clip16(((sc > penalty) ? sc : penalty) * 128);
    end else begin
      sample = n * 128;
      a = fresh_at(s, t) ? lqe_pkg::ALPHA_SLOW : lqe_pkg::ALPHA_FAST;
      if (etx_tab[s] == 0) etx_tab[s] = clip16(sample);
      else etx_tab[s] = clip16((etx_tab[s] * (lqe_pkg::SCALE - a) + sample * a)
                               / lqe_pkg::SCALE);
    end
  endfunction

  function automatic report_t predict_report(row_t r);
    report_t o;
    int s, v;
    s = r.slot;
    case (r.mode)
      lqe_pkg::MODE_TX: apply_tx(s, r.status, r.attempts, r.now);
      lqe_pkg::MODE_RX: begin
        if (!used[s]) open_entry(s);
        if (!seen[s]) begin
          rssi_tab[s] = r.rssi; seen[s] = 1;
        end else begin
          v = (int'(rssi_tab[s]) * int'(lqe_pkg::SCALE - lqe_pkg::ALPHA_SLOW)
               + int'($signed(r.rssi)) * int'(lqe_pkg::ALPHA_SLOW)) / int'(lqe_pkg::SCALE);
          rssi_tab[s] = v[7:0];
        end
        if (etx_tab[s] == 0)
          etx_tab[s] = rssi_init ? etx_from_rssi(rssi_tab[s])
                                 : 16'(lqe_pkg::DEFAULT_ETX * 128);
      end
      lqe_pkg::MODE_AGE:
        for (int i = 0; i < 16; i++) if (used[i]) fresh_tab[i] = fresh_tab[i] >> 1;
      lqe_pkg::MODE_CLEAR: for (int i = 0; i < 16; i++) used[i] = 0;
      default: ;
    endcase
    o = '{default: 0};
    if (used[s]) begin
      o.entry_valid = 1;
      o.etx = etx_tab[s];
      o.rssi = seen[s] ? rssi_tab[s] : 8'd0;
      o.rssi_known = seen[s];
      o.freshness = fresh_tab[s];
      o.fresh = fresh_at(s, r.now);
    end
    return o;
  endfunction

  task automatic write_reg(lqe_pkg::cfg_index_t idx, logic [31:0] val);
    cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    case (idx)
      lqe_pkg::CFG_ETX_FROM_COUNT: count_mode = val[0];
      lqe_pkg::CFG_INIT_ETX_RSSI:  rssi_init = val[0];
      lqe_pkg::CFG_FRESH_EXPIRY:   expiry = val;
      default:                     penalty = val[4:0];
    endcase
  endtask

  task automatic drain;
    int n;
    n = 0;
    while (pending_reports.size() != 0 && n < 20000) begin
      @(posedge clk); n++;
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic send_request(row_t r);
    report_t w;
    w = predict_report(r);
    if (r.typed && w != r.want) begin
      $display("%0t table row disagrees with shadow: expected %p, shadow %p", $time, r.want, w);
      errors++;
    end
    pending_reports.push_back(w);
    in_ch.valid <= 1; in_ch.mode <= r.mode; in_ch.slot <= r.slot;
    in_ch.tx_status <= r.status; in_ch.tx_attempts <= r.attempts;
    in_ch.rssi <= r.rssi; in_ch.now <= r.now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_source;
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic row_t rand_row(bit deep);
    row_t r;
    int p;
    p = $urandom_range(0, 99);
    r.typed = 0;
    r.want = '{default: 0};
    if (p < 45) r.mode = lqe_pkg::MODE_TX;
    else if (p < 75) r.mode = lqe_pkg::MODE_RX;
    else if (p < 85) r.mode = lqe_pkg::MODE_AGE;
    else if (p < 87) r.mode = lqe_pkg::MODE_CLEAR;
    else if (p < 95) r.mode = lqe_pkg::MODE_QUERY;
    else r.mode = lqe_pkg::mode_t'(3'($urandom_range(5, 7)));
    r.slot = deep ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
    p = $urandom_range(0, 9);
    r.status = lqe_pkg::tx_status_t'(2'((p < 5) ? 0 : (p < 8) ? 1 : $urandom_range(2, 3)));
    r.attempts = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(1, 4));
    r.rssi = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1)) r.rssi = 8'(-$urandom_range(40, 85));
    tick = tick + (($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 30000));
    r.now = tick;
    return r;
  endfunction

  // Output side: random stalls, plus a long hold-off on request.
  initial begin
    int g;
    out_ch.ready <= 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_ch.ready <= 0;
        repeat (150) @(posedge clk);
        hold_sink = 0;
      end
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) g = 0;
      if (g > 0) begin
        out_ch.ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1;
    end
  end

  always @(posedge clk) begin
    report_t got, w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.entry_valid = out_ch.entry_valid; got.etx = out_ch.etx_out;
      got.rssi = out_ch.rssi_out; got.rssi_known = out_ch.rssi_known;
      got.freshness = out_ch.freshness_out; got.fresh = out_ch.is_fresh;
      if (pending_reports.size() == 0) begin
        $display("%0t unexpected report %p", $time, got);
        errors++;
      end else begin
        w = pending_reports.pop_front();
        if (got !== w) begin
          $display("%0t report mismatch: expected %p, actual %p", $time, w, got);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t script [$];
    row_t r;
    int k;
    in_ch.valid = 0; in_ch.mode = lqe_pkg::MODE_QUERY; in_ch.slot = 0;
    in_ch.tx_status = lqe_pkg::TX_ACKED;
    in_ch.tx_attempts = 0; in_ch.rssi = 0; in_ch.now = 0;
    cfg_ch.valid = 0; cfg_ch.index = lqe_pkg::CFG_ETX_FROM_COUNT; cfg_ch.data = 0;
    count_mode = 0; rssi_init = 0; expiry = 76800; penalty = 12;
    for (int i = 0; i < 16; i++) open_entry(i);
    for (int i = 0; i < 16; i++) used[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed rows: mode, slot, status, attempts, rssi, now, typed, expected.
    script = '{
      '{lqe_pkg::MODE_QUERY, 0, lqe_pkg::TX_ACKED, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0}},
      '{lqe_pkg::MODE_TX, 15, lqe_pkg::TX_NOACK, 3, 0, 5, 1, '{0, 0, 0, 0, 0, 0}},
      '{lqe_pkg::MODE_TX, 15, lqe_pkg::TX_QFULL, 3, 0, 5, 1, '{0, 0, 0, 0, 0, 0}},
      '{lqe_pkg::MODE_TX, 15, lqe_pkg::TX_ERROR, 3, 0, 5, 1, '{0, 0, 0, 0, 0, 0}},
      '{lqe_pkg::MODE_TX, 15, lqe_pkg::TX_ACKED, 31, 0, 100, 1, '{1, 16'd3968, 0, 0, 16, 1}},
      '{lqe_pkg::MODE_TX, 15, lqe_pkg::TX_QFULL, 1, 0, 200, 0, '{default: 0}},
      '{lqe_pkg::MODE_TX, 15, lqe_pkg::TX_NOACK, 2, 0, 300, 0, '{default: 0}},
      '{lqe_pkg::MODE_RX, 0, lqe_pkg::TX_ACKED, 0, 8'h80, 400, 1,
        '{1, 16'd256, 8'h80, 1, 0, 0}},
      '{lqe_pkg::MODE_RX, 0, lqe_pkg::TX_ACKED, 0, 8'h7F, 401, 0, '{default: 0}},
      '{lqe_pkg::MODE_RX, 1, lqe_pkg::TX_ACKED, 0, 8'hC0, 402, 0, '{default: 0}},
      '{lqe_pkg::MODE_TX, 15, lqe_pkg::TX_ACKED, 1, 0, 32'hFFFFFFFF, 0, '{default: 0}},
      '{lqe_pkg::MODE_AGE, 15, lqe_pkg::TX_ACKED, 0, 0, 500, 0, '{default: 0}},
      '{lqe_pkg::mode_t'(3'd5), 15, lqe_pkg::TX_ACKED, 0, 0, 600, 0, '{default: 0}},
      '{lqe_pkg::mode_t'(3'd7), 0, lqe_pkg::TX_ACKED, 0, 0, 600, 0, '{default: 0}},
      '{lqe_pkg::MODE_CLEAR, 15, lqe_pkg::TX_ACKED, 0, 0, 700, 1, '{0, 0, 0, 0, 0, 0}},
      '{lqe_pkg::MODE_QUERY, 0, lqe_pkg::TX_ACKED, 0, 0, 700, 1, '{0, 0, 0, 0, 0, 0}}
    };
    foreach (script[i]) begin
      send_request(script[i]);
      idle_source();
    end
    in_ch.valid <= 0;
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(lqe_pkg::CFG_ETX_FROM_COUNT, 1); write_reg(lqe_pkg::CFG_NOACK_PENALTY, 0);
        end
        1: begin
          write_reg(lqe_pkg::CFG_INIT_ETX_RSSI, 1); write_reg(lqe_pkg::CFG_NOACK_PENALTY, 31);
          write_reg(lqe_pkg::CFG_FRESH_EXPIRY, 0);
        end
        2: begin
          write_reg(lqe_pkg::CFG_ETX_FROM_COUNT, 0);
          write_reg(lqe_pkg::CFG_FRESH_EXPIRY, 32'hFFFFFFFF);
        end
        3: begin
          write_reg(lqe_pkg::CFG_INIT_ETX_RSSI, 0); write_reg(lqe_pkg::CFG_FRESH_EXPIRY, 76800);
          write_reg(lqe_pkg::CFG_NOACK_PENALTY, 12);
        end
        4: begin
          write_reg(lqe_pkg::CFG_ETX_FROM_COUNT, 1);
          write_reg(lqe_pkg::CFG_FRESH_EXPIRY, $urandom());
          write_reg(lqe_pkg::CFG_NOACK_PENALTY, $urandom_range(0, 31));
        end
        default: begin
          write_reg(lqe_pkg::CFG_ETX_FROM_COUNT, 0); write_reg(lqe_pkg::CFG_INIT_ETX_RSSI, 1);
          write_reg(lqe_pkg::CFG_FRESH_EXPIRY, $urandom_range(1, 200000));
        end
      endcase
      for (k = 0; k < 230; k++) begin
        if (phase == 2 && k == 100) hold_sink = 1;
        if (phase == 3 && k == 100) begin
          in_ch.valid <= 0;
          drain();
        end
        r = rand_row($urandom_range(0, 3) != 0);
        send_request(r);
        idle_source();
      end
      in_ch.valid <= 0;
      drain();
    end

    if (pending_reports.size() != 0) begin
      $display("%0t %0d reports never arrived", $time, pending_reports.size());
      errors++;
    end
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
